// ----- rtl/sha1md_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1md_pkg
// Shared types and constants of the SHA-1 message digest core.
// ----------------------------------------------------------------------------
package sha1md_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_ADD,
    ST_DONE
  } state_e;

  // Initial chaining words, entry 0 is H0.
  localparam logic [4:0][31:0] H_INIT = {
    32'hC3D2_E1F0, 32'h1032_5476, 32'h98BA_DCFE, 32'hEFCD_AB89, 32'h6745_2301
  };

  localparam logic [31:0] K_0 = 32'h5A82_7999;
  localparam logic [31:0] K_1 = 32'h6ED9_EBA1;
  localparam logic [31:0] K_2 = 32'h8F1B_BCDC;
  localparam logic [31:0] K_3 = 32'hCA62_C1D6;

  localparam logic [7:0] PAD_MARK   = 8'h80;
  localparam logic [5:0] FILL_LAST  = 6'd63;
  localparam logic [5:0] FILL_LEN   = 6'd56;
  localparam logic [6:0] ROUND_LAST = 7'd79;
  localparam logic [3:0] LEN_LAST   = 4'd7;
  localparam logic [2:0] WORD_LAST  = 3'd4;
  localparam logic [2:0] WORD_COUNT = 3'd5;

endpackage

// ----- rtl/sha1_message_digest_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_message_digest_core
// SHA-1 over a byte stream, one shared round unit stepped by a small sequencer.
// ----------------------------------------------------------------------------
// One message byte is taken per beat while the core is ready; a beat with tlast
// closes the message. Every 64th byte starts a compression of 80 rounds, one
// round a cycle on a single round adder, followed by a fold of the result into
// the chaining words. During a compression the input is not ready. After the
// last byte the core inserts the 0x80 mark, zero bytes and the 64-bit length at
// one byte a cycle and compresses one or two more blocks. The five digest words
// then leave through a five-word output buffer, H0 first, so the core takes the
// next message while the digest still drains.
module sha1_message_digest_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tlast_i,   // last_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [31:0] digest_word, [34:32] word_index, rest zero
  output logic        m_axis_tlast_o    // last_word
);

  sha1md_pkg::state_e state_q, state_d;

  logic [4:0][31:0] h_q;
  logic [31:0]      w_q [16];
  logic [31:0]      a_q, b_q, c_q, d_q, e_q;
  logic [63:0]      bit_count_q;
  logic [5:0]       fill_q;
  logic [6:0]       round_q;
  logic [3:0]       len_q;
  logic             mark_sent_q;
  logic             pad_q;
  logic             finish_q;

  logic [31:0]      out_word_q [5];
  logic [2:0]       out_idx_q;
  logic [2:0]       out_cnt_q;

  logic             in_acc;
  logic             out_acc;
  logic             push_en;
  logic             len_push;
  logic [7:0]       push_byte;
  logic [31:0]      f_val;
  logic [31:0]      k_val;
  logic [31:0]      t_val;
  logic [31:0]      w_new;

  assign in_acc  = s_axis_tvalid_i & s_axis_tready_o;
  assign out_acc = m_axis_tvalid_o & m_axis_tready_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      sha1md_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (fill_q == sha1md_pkg::FILL_LAST) begin
            state_d = sha1md_pkg::ST_ROUND;
          end else if (s_axis_tlast_i) begin
            state_d = sha1md_pkg::ST_PAD;
          end
        end
      end
      sha1md_pkg::ST_PAD: begin
        if (fill_q == sha1md_pkg::FILL_LAST) begin
          state_d = sha1md_pkg::ST_ROUND;
        end
      end
      sha1md_pkg::ST_ROUND: begin
        if (round_q == sha1md_pkg::ROUND_LAST) begin
          state_d = sha1md_pkg::ST_ADD;
        end
      end
      sha1md_pkg::ST_ADD: begin
        if (finish_q) begin
          state_d = sha1md_pkg::ST_DONE;
        end else if (pad_q) begin
          state_d = sha1md_pkg::ST_PAD;
        end else begin
          state_d = sha1md_pkg::ST_IDLE;
        end
      end
      sha1md_pkg::ST_DONE: begin
        if (out_cnt_q == '0) begin
          state_d = sha1md_pkg::ST_IDLE;
        end
      end
      default: state_d = sha1md_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs: which byte goes into the block buffer this cycle.
  always_comb begin
    s_axis_tready_o = 1'b0;
    push_en         = 1'b0;
    len_push        = 1'b0;
    push_byte       = s_axis_tdata_i;
    case (state_q)
      sha1md_pkg::ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        push_en         = in_acc;
      end
      sha1md_pkg::ST_PAD: begin
        push_en = 1'b1;
        if (!mark_sent_q) begin
          push_byte = sha1md_pkg::PAD_MARK;
        end else if (len_q != '0 || fill_q == sha1md_pkg::FILL_LEN) begin
          len_push  = 1'b1;
          push_byte = bit_count_q[63:56];
        end else begin
          push_byte = '0;
        end
      end
      default: begin
        push_en = 1'b0;
      end
    endcase
  end

  // Round function and constant by round number.
  always_comb begin
    if (round_q < 7'd20) begin
      f_val = (b_q & c_q) | (~b_q & d_q);
      k_val = sha1md_pkg::K_0;
    end else if (round_q < 7'd40) begin
      f_val = b_q ^ c_q ^ d_q;
      k_val = sha1md_pkg::K_1;
    end else if (round_q < 7'd60) begin
      f_val = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
      k_val = sha1md_pkg::K_2;
    end else begin
      f_val = b_q ^ c_q ^ d_q;
      k_val = sha1md_pkg::K_3;
    end
  end

  assign t_val = {a_q[26:0], a_q[31:27]} + f_val + e_q + k_val + w_q[0];

  always_comb begin
    w_new = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
    w_new = {w_new[30:0], w_new[31]};
  end

  // Control and chaining state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sha1md_pkg::ST_IDLE;
      h_q         <= sha1md_pkg::H_INIT;
      bit_count_q <= '0;
      fill_q      <= '0;
      round_q     <= '0;
      len_q       <= '0;
      mark_sent_q <= 1'b0;
      pad_q       <= 1'b0;
      finish_q    <= 1'b0;
      out_idx_q   <= '0;
      out_cnt_q   <= '0;
    end else begin
      state_q <= state_d;

      if (push_en) begin
        fill_q <= fill_q + 6'd1;
      end
      if (in_acc) begin
        bit_count_q <= bit_count_q + 64'd8;
        if (s_axis_tlast_i) begin
          pad_q <= 1'b1;
        end
      end
      if (state_q == sha1md_pkg::ST_PAD) begin
        mark_sent_q <= 1'b1;
        if (len_push) begin
          // The length leaves most significant byte first.
          bit_count_q <= {bit_count_q[55:0], 8'h00};
          len_q       <= len_q + 4'd1;
          if (len_q == sha1md_pkg::LEN_LAST) begin
            finish_q <= 1'b1;
          end
        end
      end

      if (state_q == sha1md_pkg::ST_ROUND) begin
        round_q <= round_q + 7'd1;
      end else begin
        round_q <= '0;
      end

      if (state_q == sha1md_pkg::ST_ADD) begin
        h_q[0] <= h_q[0] + a_q;
        h_q[1] <= h_q[1] + b_q;
        h_q[2] <= h_q[2] + c_q;
        h_q[3] <= h_q[3] + d_q;
        h_q[4] <= h_q[4] + e_q;
      end

      if (state_q == sha1md_pkg::ST_DONE && out_cnt_q == '0) begin
        out_idx_q   <= '0;
        out_cnt_q   <= sha1md_pkg::WORD_COUNT;
        h_q         <= sha1md_pkg::H_INIT;
        bit_count_q <= '0;
        fill_q      <= '0;
        len_q       <= '0;
        mark_sent_q <= 1'b0;
        pad_q       <= 1'b0;
        finish_q    <= 1'b0;
      end else if (out_acc) begin
        out_idx_q <= out_idx_q + 3'd1;
        out_cnt_q <= out_cnt_q - 3'd1;
      end
    end
  end

  // Block buffer as sixteen big-endian words; during rounds it runs as the
  // message schedule, so word 0 always holds the current round's word.
  always_ff @(posedge clk_i) begin
    if (push_en) begin
      case (fill_q[1:0])
        2'd0:    w_q[fill_q[5:2]][31:24] <= push_byte;
        2'd1:    w_q[fill_q[5:2]][23:16] <= push_byte;
        2'd2:    w_q[fill_q[5:2]][15:8]  <= push_byte;
        default: w_q[fill_q[5:2]][7:0]   <= push_byte;
      endcase
    end else if (state_q == sha1md_pkg::ST_ROUND) begin
      for (int i = 0; i < 15; i++) begin
        w_q[i] <= w_q[i + 1];
      end
      w_q[15] <= w_new;
    end
  end

  // Working variables: loaded as a block fills, stepped once per round.
  always_ff @(posedge clk_i) begin
    if (state_q == sha1md_pkg::ST_ROUND) begin
      a_q <= t_val;
      b_q <= a_q;
      c_q <= {b_q[1:0], b_q[31:2]};
      d_q <= c_q;
      e_q <= d_q;
    end else if (push_en && fill_q == sha1md_pkg::FILL_LAST) begin
      a_q <= h_q[0];
      b_q <= h_q[1];
      c_q <= h_q[2];
      d_q <= h_q[3];
      e_q <= h_q[4];
    end
  end

  // Digest output buffer, drained one word per beat.
  always_ff @(posedge clk_i) begin
    if (state_q == sha1md_pkg::ST_DONE && out_cnt_q == '0) begin
      for (int i = 0; i < 5; i++) begin
        out_word_q[i] <= h_q[i];
      end
    end else if (out_acc) begin
      for (int i = 0; i < 4; i++) begin
        out_word_q[i] <= out_word_q[i + 1];
      end
      out_word_q[4] <= out_word_q[0];
    end
  end

  assign m_axis_tvalid_o = (out_cnt_q != '0);
  assign m_axis_tdata_o  = {5'b0, out_idx_q, out_word_q[0]};
  assign m_axis_tlast_o  = (out_idx_q == sha1md_pkg::WORD_LAST);

endmodule
